// ===== hw/rtl/hts_pkg.sv =====
// Shared types, constants and codes for the heightfield triangle height sampler.
package hts_pkg;

    localparam int GRID_SIZE_DEF = 128;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int HEIGHT_W    = 20;
    localparam int WEIGHT_W    = 17;
    localparam int ACC_W       = 37;

    localparam logic signed [10:0] MIN_HEIGHT_RST  = -11'sd80;
    localparam logic signed [10:0] MAX_HEIGHT_RST  = 11'sd300;
    localparam logic [18:0]        HALF_EXTENT_RST = 19'd102400;
    localparam logic [19:0]        INV_SPACING_RST = 20'd10445;

    // ceil(2^28 / 255): exact floor division by 255 for operands below 2^20.
    localparam logic [20:0] RECIP_255   = 21'd1052689;
    localparam logic [6:0]  ROUND_BIAS  = 7'd127;
    localparam logic [16:0] FRAC_ONE    = 17'h10000;
    localparam logic signed [ACC_W-1:0] HALF_LSB = 37'sd32768;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_HEIGHT  = 2'd0,
        CFG_MAX_HEIGHT  = 2'd1,
        CFG_HALF_EXTENT = 2'd2,
        CFG_INV_SPACING = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        CORNER_A = 2'd0,
        CORNER_B = 2'd1,
        CORNER_C = 2'd2
    } corner_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_DIV,
        ST_LD_WRITE,
        ST_MAP_X,
        ST_MAP_Z,
        ST_CHECK,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_MAC,
        ST_SUM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               mode;
        logic [6:0]         grid_x;
        logic [6:0]         grid_z;
        logic [7:0]         raw_height;
        logic signed [19:0] world_x;
        logic signed [19:0] world_z;
    } in_item_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic                       in_range;
    } out_item_t;

    typedef struct packed {
        logic    capture;
        logic    ld_mul;
        logic    ld_div;
        logic    ld_write;
        logic    map_en;
        logic    map_z;
        logic    check;
        logic    rd_en;
        corner_t rd_corner;
        logic    prod_en;
        corner_t prod_sel;
        logic    acc_load;
        logic    acc_add;
        logic    out_load;
    } hts_cmd_t;

    typedef struct packed {
        logic range_ok;
        logic out_free;
    } hts_status_t;

endpackage

// ===== hw/rtl/hts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module hts_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hts_ctrl.sv =====
// Sequencer that steps one load or query transaction through the datapath.
module hts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_mode,
    input  hts_pkg::hts_status_t status,
    output logic                 in_stall,
    output hts_pkg::hts_cmd_t    cmd
);

    import hts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_mode == MODE_QUERY) ? ST_MAP_X : ST_LD_MUL;
                end
            end
            ST_LD_MUL:   state_next = ST_LD_DIV;
            ST_LD_DIV:   state_next = ST_LD_WRITE;
            ST_LD_WRITE: state_next = ST_IDLE;
            ST_MAP_X:    state_next = ST_MAP_Z;
            ST_MAP_Z:    state_next = ST_CHECK;
            // An out-of-range position skips the corner reads entirely.
            ST_CHECK:    state_next = status.range_ok ? ST_RD0 : ST_FINISH;
            ST_RD0:      state_next = ST_RD1;
            ST_RD1:      state_next = ST_RD2;
            ST_RD2:      state_next = ST_MAC;
            ST_MAC:      state_next = ST_SUM;
            ST_SUM:      state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd_corner = CORNER_A;
        cmd.prod_sel = CORNER_A;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.capture = in_valid;
            end
            ST_LD_MUL:   cmd.ld_mul = 1'b1;
            ST_LD_DIV:   cmd.ld_div = 1'b1;
            ST_LD_WRITE: cmd.ld_write = 1'b1;
            ST_MAP_X:    cmd.map_en = 1'b1;
            ST_MAP_Z:
            begin
                cmd.map_en = 1'b1;
                cmd.map_z = 1'b1;
            end
            ST_CHECK:    cmd.check = 1'b1;
            ST_RD0:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_corner = CORNER_A;
            end
            ST_RD1:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_corner = CORNER_B;
                cmd.prod_en = 1'b1;
                cmd.prod_sel = CORNER_A;
            end
            ST_RD2:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_corner = CORNER_C;
                cmd.prod_en = 1'b1;
                cmd.prod_sel = CORNER_B;
                cmd.acc_load = 1'b1;
            end
            ST_MAC:
            begin
                cmd.prod_en = 1'b1;
                cmd.prod_sel = CORNER_C;
                cmd.acc_add = 1'b1;
            end
            ST_SUM:      cmd.acc_add = 1'b1;
            ST_FINISH:   cmd.out_load = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/hts_datapath.sv =====
// Datapath: configuration registers, pixel scaling, axis mapping, grid store and weighted sum.
module hts_datapath #(
    parameter int GRID_SIZE = hts_pkg::GRID_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  hts_pkg::in_item_t                  in_item,
    input  hts_pkg::hts_cmd_t                  cmd,
    output hts_pkg::hts_status_t               status,
    output logic                               out_valid,
    input  logic                               out_stall,
    output hts_pkg::out_item_t                 out_item
);

    import hts_pkg::*;

    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CELL_W = $clog2(GRID_SIZE);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(GRID_SIZE);
    localparam logic [ADDR_W-1:0] COL_STEP   = ADDR_W'(1);
    localparam logic [15:0]       CELL_LIMIT = 16'(GRID_SIZE - 1);

    // Configuration registers.
    logic signed [10:0] min_reg;
    logic signed [10:0] max_reg;
    logic [18:0]        half_reg;
    logic [19:0]        inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= MIN_HEIGHT_RST;
            max_reg  <= MAX_HEIGHT_RST;
            half_reg <= HALF_EXTENT_RST;
            inv_reg  <= INV_SPACING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_HEIGHT:  min_reg  <= cfg_data[10:0];
                CFG_MAX_HEIGHT:  max_reg  <= cfg_data[10:0];
                CFG_HALF_EXTENT: half_reg <= cfg_data[18:0];
                CFG_INV_SPACING: inv_reg  <= cfg_data;
                default:         min_reg  <= min_reg;
            endcase
        end
    end

    // Captured transaction and shifted positions.
    in_item_t           in_reg;
    logic signed [20:0] tx_reg;
    logic signed [20:0] tz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_item;
            tx_reg <= 21'(in_item.world_x) + $signed({2'b00, half_reg});
            tz_reg <= 21'(in_item.world_z) + $signed({2'b00, half_reg});
        end
    end

    // Pixel scaling: q = round(raw * |max - min| * 256 / 255), sign applied afterwards.
    logic signed [11:0] diff;
    logic signed [11:0] hsum;
    logic [10:0]        mag;
    logic [18:0]        x_reg;
    logic [10:0]        quo_reg;
    logic [19:0]        div_in;
    logic [40:0]        div_prod;
    logic [19:0]        q_mag;
    logic signed [22:0] q_signed;
    logic signed [22:0] wval;
    logic               ld_in_grid;
    logic [ADDR_W-1:0]  ld_addr;

    assign diff     = 12'(max_reg) - 12'(min_reg);
    assign hsum     = 12'(min_reg) + 12'(max_reg);
    assign mag      = diff[11] ? 11'(-diff) : diff[10:0];
    assign div_in   = {1'b0, x_reg} + {13'b0, ROUND_BIAS};
    assign div_prod = {21'b0, div_in} * {20'b0, RECIP_255};

    always_ff @(posedge clk)
    begin
        if (cmd.ld_mul)
        begin
            x_reg <= {11'b0, in_reg.raw_height} * {8'b0, mag};
        end
        if (cmd.ld_div)
        begin
            quo_reg <= div_prod[38:28];
        end
    end

    // 256x/255 = x + x/255, so the rounded quotient is x + floor((x + 127) / 255).
    assign q_mag    = {1'b0, x_reg} + {9'b0, quo_reg};
    assign q_signed = diff[11] ? -$signed({3'b000, q_mag}) : $signed({3'b000, q_mag});
    assign wval     = (23'(min_reg) <<< 8) + q_signed - (23'(hsum) <<< 7);

    assign ld_in_grid = (int'(in_reg.grid_x) < GRID_SIZE) && (int'(in_reg.grid_z) < GRID_SIZE);
    assign ld_addr    = ADDR_W'(in_reg.grid_z) * ROW_STEP + ADDR_W'(in_reg.grid_x);

    // Axis mapping, one axis per cycle on a shared multiplier.
    logic signed [20:0] t_sel;
    logic [39:0]        g;
    logic [15:0]        cell_idx;
    logic               axis_ok;
    logic [CELL_W-1:0]  cx_reg;
    logic [CELL_W-1:0]  cz_reg;
    logic [15:0]        fx_reg;
    logic [15:0]        fz_reg;
    logic               okx_reg;
    logic               okz_reg;

    assign t_sel    = cmd.map_z ? tz_reg : tx_reg;
    assign g        = {20'b0, t_sel[19:0]} * {20'b0, inv_reg};
    assign cell_idx = g[39:24];
    assign axis_ok  = !t_sel[20] && (cell_idx < CELL_LIMIT);

    always_ff @(posedge clk)
    begin
        if (cmd.map_en && !cmd.map_z)
        begin
            cx_reg  <= cell_idx[CELL_W-1:0];
            fx_reg  <= g[23:8];
            okx_reg <= axis_ok;
        end
        if (cmd.map_en && cmd.map_z)
        begin
            cz_reg  <= cell_idx[CELL_W-1:0];
            fz_reg  <= g[23:8];
            okz_reg <= axis_ok;
        end
    end

    // Triangle choice and barycentric weights.
    logic [16:0]         fsum;
    logic                upper;
    logic                upper_reg;
    logic [WEIGHT_W-1:0] w0_reg;
    logic [WEIGHT_W-1:0] w1_reg;
    logic [WEIGHT_W-1:0] w2_reg;
    logic [ADDR_W-1:0]   base_reg;

    assign fsum  = {1'b0, fx_reg} + {1'b0, fz_reg};
    assign upper = fsum > FRAC_ONE;

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            upper_reg <= upper;
            base_reg  <= ADDR_W'(cz_reg) * ROW_STEP + ADDR_W'(cx_reg);
            if (upper)
            begin
                w0_reg <= FRAC_ONE - {1'b0, fz_reg};
                w1_reg <= fsum - FRAC_ONE;
                w2_reg <= FRAC_ONE - {1'b0, fx_reg};
            end
            else
            begin
                w0_reg <= FRAC_ONE - fsum;
                w1_reg <= {1'b0, fx_reg};
                w2_reg <= {1'b0, fz_reg};
            end
        end
    end

    // Corner addresses: lower triangle reads (x,z), (x+1,z), (x,z+1);
    // upper triangle reads (x+1,z), (x+1,z+1), (x,z+1).
    logic [ADDR_W-1:0] rd_off;
    logic [ADDR_W-1:0] raddr;
    logic [HEIGHT_W-1:0] rdata;

    always_comb
    begin
        case (cmd.rd_corner)
            CORNER_A: rd_off = upper_reg ? COL_STEP : '0;
            CORNER_B: rd_off = upper_reg ? (ROW_STEP + COL_STEP) : COL_STEP;
            CORNER_C: rd_off = ROW_STEP;
            default:  rd_off = '0;
        endcase
    end

    assign raddr = base_reg + rd_off;

    hts_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (cmd.ld_write && ld_in_grid),
        .waddr (ld_addr),
        .wdata (wval[HEIGHT_W-1:0]),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Multiply-accumulate over the three corners.
    logic [WEIGHT_W-1:0]       w_sel;
    logic signed [37:0]        prod_full;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   rnd;

    always_comb
    begin
        case (cmd.prod_sel)
            CORNER_A: w_sel = w0_reg;
            CORNER_B: w_sel = w1_reg;
            CORNER_C: w_sel = w2_reg;
            default:  w_sel = '0;
        endcase
    end

    assign prod_full = $signed(rdata) * $signed({1'b0, w_sel});

    always_ff @(posedge clk)
    begin
        if (cmd.prod_en)
        begin
            prod_reg <= prod_full[ACC_W-1:0];
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign rnd = acc_reg + HALF_LSB;

    // Output register.
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      range_ok;

    assign range_ok = okx_reg && okz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.height   <= range_ok ? rnd[HEIGHT_W+15:16] : '0;
            out_item_reg.in_range <= range_ok;
        end
    end

    assign status.range_ok = range_ok;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

endmodule

// ===== hw/rtl/heightfield_triangle_height_sampler.sv =====
// Top level of the heightfield triangle height sampler: sequencer plus datapath.
// A load steps through multiply, divide and write states. An in-range query steps through
// axis mapping, the range check, three corner reads, multiply-accumulate and the sum;
// an out-of-range query goes from the check to its result. The three corner reads share
// one grid RAM read port. Reset restores the register defaults and clears the sequencer
// and output valid; the grid contents stay undefined until loaded.
module heightfield_triangle_height_sampler #(
    parameter int GRID_SIZE = hts_pkg::GRID_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  hts_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output hts_pkg::out_item_t              out_item
);

    import hts_pkg::*;

    hts_cmd_t    cmd;
    hts_status_t status;

    hts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (in_item.mode),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    hts_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ===== hw/rtl/hts_checker.sv =====
// Port-level assertions for the heightfield triangle height sampler, bound to the top level.
module hts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input hts_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input hts_pkg::out_item_t out_item
);

    import hts_pkg::*;

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

    // An out-of-range result always carries a zero height.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.in_range |-> out_item.height == '0)
    else $error("out-of-range result with nonzero height");

    // Every accepted transaction keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

    // A new result only appears after the block has been busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

    // A load produces no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.mode == MODE_LOAD && !out_valid |=> !out_valid)
    else $error("load transaction produced a result");

endmodule

bind heightfield_triangle_height_sampler hts_checker u_checker (.*);

// ===== tb/sv/heightfield_triangle_height_sampler_tb.sv =====
// Self-checking testbench for the heightfield triangle height sampler.
`timescale 1ns / 100ps

module heightfield_triangle_height_sampler_tb;
    import hts_pkg::*;

    localparam int GRID = GRID_SIZE_DEF;
    localparam longint UNIT = 65536;
    localparam int SETTLE = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic signed [19:0] FAR_NEGATIVE = 20'sh80000;

    typedef struct {
        int x;
        int z;
    } cell_t;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MIN_HEIGHT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;

    // Local copy of the block's registers and height grid.
    logic signed [10:0] min_h;
    logic signed [10:0] max_h;
    logic [18:0]        half_ext;
    logic [19:0]        inv_sp;
    logic signed [19:0] terrain [GRID*GRID];
    bit                 loaded [GRID*GRID];
    bit                 cell_listed [GRID*GRID];
    cell_t              ready_cells [$];

    out_item_t expected_heights [$];
    stim_row_t directed_rows [$];
    int        error_count = 0;
    int        items_sent = 0;
    int        quiet_cycles = 0;
    int        hold_off_cycles = 0;
    bit        idle_on = 1'b0;
    bit        allow_idle = 1'b1;

    heightfield_triangle_height_sampler #(
        .GRID_SIZE(GRID)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #6 clk = ~clk;

    function automatic logic signed [19:0] pixel_height(input logic [7:0] raw);
        int     span;
        longint mag;
        longint q;
        longint v;
        span = int'(max_h) - int'(min_h);
        mag = (span < 0) ? -span : span;
        // Round the magnitude first, then apply the sign of the span.
        q = (longint'(raw) * mag * 256 + 127) / 255;
        if (span < 0)
            q = -q;
        v = longint'(min_h) * 256 + q - (longint'(min_h) + longint'(max_h)) * 128;
        return v[19:0];
    endfunction

    function automatic bit axis_cell(input logic signed [19:0] w, output int cell_idx,
                                     output longint frac);
        longint t;
        longint g;
        cell_idx = 0;
        frac = 0;
        t = longint'(w) + longint'(half_ext);
        if (t < 0)
            return 1'b0;
        g = t * longint'(inv_sp);
        if ((g >>> 24) >= GRID - 1)
            return 1'b0;
        cell_idx = int'(g >>> 24);
        frac = (g >>> 8) & 64'hFFFF;
        return 1'b1;
    endfunction

    function automatic out_item_t query_height(input in_item_t it);
        out_item_t r;
        int        cx;
        int        cz;
        longint    fx;
        longint    fz;
        longint    h00;
        longint    h10;
        longint    h01;
        longint    h11;
        longint    num;
        r = '0;
        if (!axis_cell(it.world_x, cx, fx) || !axis_cell(it.world_z, cz, fz))
            return r;
        h00 = terrain[cz*GRID + cx];
        h10 = terrain[cz*GRID + cx + 1];
        h01 = terrain[(cz+1)*GRID + cx];
        h11 = terrain[(cz+1)*GRID + cx + 1];
        if (fx <= UNIT - fz)
            num = h00 * (UNIT - fx - fz) + h10 * fx + h01 * fz;
        else
            num = h10 * (UNIT - fz) + h11 * (fx + fz - UNIT) + h01 * (UNIT - fx);
        num = (num + 32768) >>> 16;
        r.height = num[19:0];
        r.in_range = 1'b1;
        return r;
    endfunction

    // A query is safe when it falls outside or all four corners of its cell are loaded.
    function automatic bit query_reads_ok(input in_item_t it);
        int     cx;
        int     cz;
        longint fx;
        longint fz;
        if (!axis_cell(it.world_x, cx, fx) || !axis_cell(it.world_z, cz, fz))
            return 1'b1;
        return loaded[cz*GRID + cx] && loaded[cz*GRID + cx + 1]
            && loaded[(cz+1)*GRID + cx] && loaded[(cz+1)*GRID + cx + 1];
    endfunction

    function automatic void store_pixel(input in_item_t it);
        int x;
        int z;
        int cx;
        int cz;
        x = int'(it.grid_x);
        z = int'(it.grid_z);
        terrain[z*GRID + x] = pixel_height(it.raw_height);
        loaded[z*GRID + x] = 1'b1;
        for (cz = z - 1; cz <= z; cz++)
            for (cx = x - 1; cx <= x; cx++)
                if (cx >= 0 && cz >= 0 && cx < GRID - 1 && cz < GRID - 1
                    && !cell_listed[cz*GRID + cx]
                    && loaded[cz*GRID + cx] && loaded[cz*GRID + cx + 1]
                    && loaded[(cz+1)*GRID + cx] && loaded[(cz+1)*GRID + cx + 1]) begin
                    cell_listed[cz*GRID + cx] = 1'b1;
                    ready_cells.push_back('{cx, cz});
                end
    endfunction

    function automatic in_item_t random_item(input mode_t m);
        logic [63:0] bits;
        in_item_t    it;
        bits = {$urandom(), $urandom()};
        it = bits[$bits(in_item_t)-1:0];
        it.mode = m;
        return it;
    endfunction

    function automatic in_item_t load_item(input int x, input int z, input int raw);
        in_item_t it;
        it = random_item(MODE_LOAD);
        it.grid_x = 7'(x);
        it.grid_z = 7'(z);
        it.raw_height = 8'(raw);
        return it;
    endfunction

    function automatic in_item_t query_item(input int wx, input int wz);
        in_item_t it;
        it = random_item(MODE_QUERY);
        it.world_x = 20'(wx);
        it.world_z = 20'(wz);
        return it;
    endfunction

    // World coordinate whose mapped position is at or just past the given cell and fraction.
    function automatic bit axis_world(input int cell_idx, input int frac,
                                      output logic signed [19:0] w);
        longint g;
        longint t;
        g = (longint'(cell_idx) << 24) + (longint'(frac) << 8);
        if (inv_sp == 0)
            t = $urandom_range(0, 4095);
        else
            t = (g + longint'(inv_sp) - 1) / longint'(inv_sp);
        t = t - longint'(half_ext);
        w = t[19:0];
        return (t >= -524288 && t <= 524287);
    endfunction

    function automatic in_item_t aimed_query(input int cx, input int cz, input int fx,
                                             input int fz);
        in_item_t           it;
        logic signed [19:0] wx;
        logic signed [19:0] wz;
        it = random_item(MODE_QUERY);
        if (axis_world(cx, fx, wx) && axis_world(cz, fz, wz)) begin
            it.world_x = wx;
            it.world_z = wz;
        end else begin
            it.world_x = FAR_NEGATIVE;
        end
        return it;
    endfunction

    function automatic in_item_t make_query();
        cell_t    c;
        int       fx;
        int       fz;
        in_item_t it;
        c = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
        case ($urandom_range(0, 3))
            0: begin
                // Right on the anti-diagonal, which belongs to the lower triangle.
                fx = 256 * $urandom_range(1, 255);
                fz = int'(UNIT - fx);
            end
            1: begin
                fx = 65535 * $urandom_range(0, 1);
                fz = 65535 * $urandom_range(0, 1);
            end
            default: begin
                fx = $urandom_range(0, 65535);
                fz = $urandom_range(0, 65535);
            end
        endcase
        it = aimed_query(c.x, c.z, fx, fz);
        if (!query_reads_ok(it))
            it.world_x = FAR_NEGATIVE;
        return it;
    endfunction

    function automatic void add_row(input in_item_t it, input bit typed, input int h,
                                    input bit r);
        stim_row_t row;
        row.item = it;
        row.typed = typed;
        row.want.height = 20'(h);
        row.want.in_range = r;
        directed_rows.push_back(row);
    endfunction

    task automatic send_transaction(input in_item_t it, input bit typed, input out_item_t want);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (it.mode == MODE_LOAD)
            store_pixel(it);
        else
            expected_heights.push_back(typed ? want : query_height(it));
    endtask

    task automatic await_results();
        in_valid <= 1'b0;
        while (expected_heights.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Called only when the block is idle.
    task automatic program_regs(input int lo, input int hi, input int half, input int inv);
        write_reg(CFG_MIN_HEIGHT, 20'(lo));
        write_reg(CFG_MAX_HEIGHT, 20'(hi));
        write_reg(CFG_HALF_EXTENT, 20'(half));
        write_reg(CFG_INV_SPACING, 20'(inv));
        cfg_we <= 1'b0;
        min_h = 11'(lo);
        max_h = 11'(hi);
        half_ext = 19'(half);
        inv_sp = 20'(inv);
    endtask

    task automatic run_random(input int budget);
        int       stop_at;
        int       bx;
        int       bz;
        int       k;
        in_item_t it;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if (items_sent % 40 == 0)
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // Load a 2x2 patch so that its cell becomes queryable.
                    bx = $urandom_range(0, GRID - 2);
                    bz = $urandom_range(0, GRID - 2);
                    for (k = 0; k < 4; k++)
                        send_transaction(load_item(bx + k % 2, bz + k / 2,
                                                   $urandom_range(0, 255)), 1'b0, '0);
                end
                9: begin
                    if ($urandom_range(0, 1)) begin
                        it = load_item($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                                       $urandom_range(0, 255));
                    end else begin
                        it = random_item(MODE_QUERY);
                        if (!query_reads_ok(it))
                            it.world_x = FAR_NEGATIVE;
                    end
                    send_transaction(it, 1'b0, '0);
                end
                default: send_transaction(make_query(), 1'b0, '0);
            endcase
        end
    endtask

    // Receiver side: random short stalls, or one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_heights.size() == 0) begin
                $display("%0t: result with none expected, height %0d in_range %0b",
                         $time, out_item.height, out_item.in_range);
                error_count++;
            end else begin
                want = expected_heights.pop_front();
                if (out_item.height !== want.height) begin
                    $display("%0t: height expected %0d actual %0d",
                             $time, want.height, out_item.height);
                    error_count++;
                end
                if (out_item.in_range !== want.in_range) begin
                    $display("%0t: in_range expected %0b actual %0b",
                             $time, want.in_range, out_item.in_range);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int i;
        int k;
        min_h = MIN_HEIGHT_RST;
        max_h = MAX_HEIGHT_RST;
        half_ext = HALF_EXTENT_RST;
        inv_sp = INV_SPACING_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the register values left by reset.
        add_row(load_item(0, 0, 0), 1'b0, 0, 1'b0);
        add_row(load_item(1, 0, 255), 1'b0, 0, 1'b0);
        add_row(load_item(0, 1, 128), 1'b0, 0, 1'b0);
        add_row(load_item(1, 1, 1), 1'b0, 0, 1'b0);
        add_row(load_item(2, 0, 0), 1'b0, 0, 1'b0);
        add_row(load_item(2, 1, 255), 1'b0, 0, 1'b0);
        // Aimed queries near a cell edge can land one cell further on.
        add_row(load_item(0, 2, 60), 1'b0, 0, 1'b0);
        add_row(load_item(1, 2, 190), 1'b0, 0, 1'b0);
        add_row(load_item(2, 2, 33), 1'b0, 0, 1'b0);
        add_row(load_item(126, 126, 77), 1'b0, 0, 1'b0);
        add_row(load_item(127, 126, 200), 1'b0, 0, 1'b0);
        add_row(load_item(126, 127, 0), 1'b0, 0, 1'b0);
        add_row(load_item(127, 127, 255), 1'b0, 0, 1'b0);
        // Exactly on corner (0,0): the raw-zero height.
        add_row(query_item(-102400, -102400), 1'b1, -48640, 1'b1);
        add_row(query_item(-102401, 0), 1'b1, 0, 1'b0);
        add_row(query_item(-102400, -102401), 1'b1, 0, 1'b0);
        add_row(query_item(-524288, -524288), 1'b1, 0, 1'b0);
        add_row(query_item(524287, 524287), 1'b1, 0, 1'b0);
        add_row(query_item(524287, -102400), 1'b1, 0, 1'b0);
        add_row(aimed_query(GRID - 1, GRID - 1, 0, 0), 1'b1, 0, 1'b0);
        add_row(aimed_query(GRID - 2, GRID - 2, 65535, 65535), 1'b0, 0, 1'b0);
        add_row(aimed_query(GRID - 2, GRID - 2, 12345, 40000), 1'b0, 0, 1'b0);
        add_row(aimed_query(0, 0, 32768, 32768), 1'b0, 0, 1'b0);
        add_row(aimed_query(0, 0, 65535, 65535), 1'b0, 0, 1'b0);
        add_row(aimed_query(1, 0, 0, 65535), 1'b0, 0, 1'b0);
        add_row(load_item(0, 0, 255), 1'b0, 0, 1'b0);
        add_row(query_item(-102400, -102400), 1'b1, 48640, 1'b1);
        idle_on = 1'b1;
        for (i = 0; i < directed_rows.size(); i++)
            send_transaction(directed_rows[i].item, directed_rows[i].typed,
                             directed_rows[i].want);

        await_results();
        repeat (SETTLE) @(posedge clk);
        // Unit spacing, no offset, widest height span.
        program_regs(-1024, 1023, 0, 65536);
        run_random(230);

        await_results();
        repeat (SETTLE) @(posedge clk);
        // Inverted span, largest offset and finest spacing.
        program_regs(1023, -1024, 524287, 1048575);
        run_random(230);

        await_results();
        repeat (SETTLE) @(posedge clk);
        // Zero reciprocal spacing: every reachable position lands on corner (0,0).
        program_regs(-1, 0, 0, 0);
        run_random(60);

        await_results();
        repeat (SETTLE) @(posedge clk);
        program_regs($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                     $urandom_range(0, 524287), $urandom_range(5000, 600000));
        // Hold the output off while queries keep coming, so the block backs up.
        idle_on = 1'b0;
        hold_off_cycles = 80;
        for (k = 0; k < 24; k++)
            send_transaction(make_query(), 1'b0, '0);
        await_results();
        run_random(280);

        await_results();
        repeat (SETTLE) @(posedge clk);
        allow_idle = 1'b0;
        idle_on = 1'b0;
        program_regs($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                     HALF_EXTENT_RST, INV_SPACING_RST);
        run_random(200);

        await_results();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== heightfield_triangle_height_sampler.f =====
hw/rtl/hts_pkg.sv
hw/rtl/hts_ram.sv
hw/rtl/hts_ctrl.sv
hw/rtl/hts_datapath.sv
hw/rtl/heightfield_triangle_height_sampler.sv
hw/rtl/hts_checker.sv
tb/sv/heightfield_triangle_height_sampler_tb.sv
